// ===== sv/cwt_pkg.sv =====
// Package for the cotangent weight triplet block: field widths, derived
// datapath widths and the payload structs of both channels.
// No dependencies.
package cwt_pkg;

    localparam int INDEX_BITS  = 24;
    localparam int COORD_BITS  = 16;
    localparam int WEIGHT_BITS = 32;
    localparam int FRAC_BITS   = 16;

    // datapath widths, all exact
    localparam int DIFF_W  = COORD_BITS + 1;   // edge vector component
    localparam int PROD_W  = 2 * DIFF_W;       // one product
    localparam int DOT_W   = PROD_W + 2;       // sum of three products
    localparam int CROSS_W = PROD_W + 1;       // cross component
    localparam int SQ_W    = 2 * CROSS_W;      // squared cross component
    localparam int SUM_W   = SQ_W + 2;         // squared norm, even width
    localparam int ROOT_W  = SUM_W / 2;        // norm
    localparam int REM_W   = ROOT_W + 2;       // root remainder
    localparam int NUM_W   = DOT_W + FRAC_BITS; // dividend
    localparam int DREM_W  = ROOT_W + 1;       // divider remainder

    typedef struct packed {
        logic [INDEX_BITS-1:0]        index_a;
        logic [INDEX_BITS-1:0]        index_b;
        logic [INDEX_BITS-1:0]        index_c;
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] az;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by;
        logic signed [COORD_BITS-1:0] bz;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic signed [COORD_BITS-1:0] cz;
    } t_in;

    typedef struct packed {
        logic [INDEX_BITS-1:0]         row_index;
        logic [INDEX_BITS-1:0]         col_index;
        logic signed [WEIGHT_BITS-1:0] weight;
        logic                          last;
    } t_out;

    typedef struct packed {
        logic [INDEX_BITS-1:0] a;
        logic [INDEX_BITS-1:0] b;
        logic [INDEX_BITS-1:0] c;
    } t_idx;

endpackage

// ===== sv/cotangent_weight_triplets.sv =====
// Cotangent Laplacian weight generator, top level.
// Depends on cwt_pkg.
//
// Usage:
//   Input channel (i_valid / o_ready / i_data) takes one triangle per item:
//   three vertex indices and the three corners in signed Q8.8.
//   Output channel (o_valid / i_ready / o_data) gives three triplets per
//   triangle, in order (a,b) with the cotangent at c, (c,a) at b, (b,c) at a;
//   last marks the third one. Weights are Q16.16, truncated, saturated;
//   a degenerate triangle gives weight 0.
//   The single output port sets the rate: the serializer in front of the
//   divider holds each triangle until its three divisions have gone out.
//   Stages: 5 + ROOT_W front stages (diffs, products, sums, squares,
//   norm sum, one root bit per stage), one serializer stage, NUM_W divider
//   stages (one quotient bit each), one output register.
//   Reset (synchronous, active low) empties every stage; no clearing pass.
//   When the receiver stalls the whole back end holds, the serializer holds,
//   and o_ready drops so the front end freezes; nothing is lost or repeated.
module cotangent_weight_triplets (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  cwt_pkg::t_in   i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output cwt_pkg::t_out  o_data
);
    import cwt_pkg::*;

    localparam int FRONT = 5 + ROOT_W;   // front stages up to the norm

    // handshake control
    logic b_adv;     // back end (divider, output) moves
    logic f_adv;     // front end moves, serializer reloads

    // front side band: valid, indices, dot products
    logic r_fv [FRONT];
    t_idx r_fidx [FRONT];
    logic signed [DOT_W-1:0] r_fdot [FRONT-2][3];  // [0]=at c, [1]=at b, [2]=at a

    // corner coordinates as arrays
    logic signed [COORD_BITS-1:0] w_a [3];
    logic signed [COORD_BITS-1:0] w_b [3];
    logic signed [COORD_BITS-1:0] w_c [3];

    // stage 1: edge vectors
    logic signed [DIFF_W-1:0] r_dba [3];
    logic signed [DIFF_W-1:0] r_dca [3];
    logic signed [DIFF_W-1:0] r_dcb [3];
    logic signed [DIFF_W-1:0] r_dab [3];
    // stage 2: products
    logic signed [PROD_W-1:0] r_pc [3];
    logic signed [PROD_W-1:0] r_pb [3];
    logic signed [PROD_W-1:0] r_pa [3];
    logic signed [PROD_W-1:0] r_xp [3];
    logic signed [PROD_W-1:0] r_xn [3];
    // stage 3: cross components
    logic signed [CROSS_W-1:0] r_cr [3];
    // stage 4: squares
    logic [SQ_W-1:0] r_sq [3];
    logic [CROSS_W-1:0] w_mag [3];
    // stage 5: squared norm
    logic [SUM_W-1:0] r_sum;
    // root stages
    logic [REM_W-1:0]  r_srem [ROOT_W];
    logic [ROOT_W-1:0] r_sroot [ROOT_W];
    logic [SUM_W-1:0]  r_srad [ROOT_W];
    logic [REM_W-1:0]  n_srem [ROOT_W];
    logic [ROOT_W-1:0] n_sroot [ROOT_W];
    logic [SUM_W-1:0]  n_srad [ROOT_W];

    // serializer
    logic                    r_ser_v;
    logic [1:0]              r_cnt;
    t_idx                    r_ser_idx;
    logic signed [DOT_W-1:0] r_ser_dot [3];
    logic [ROOT_W-1:0]       r_ser_norm;
    logic signed [DOT_W-1:0] w_sel_dot;
    logic [DOT_W-1:0]        w_sel_mag;
    logic [NUM_W-1:0]        w_sel_num;
    logic [INDEX_BITS-1:0]   w_sel_row;
    logic [INDEX_BITS-1:0]   w_sel_col;
    logic                    w_sel_last;

    // divider stages
    logic                  r_dv [NUM_W];
    logic [DREM_W-1:0]     r_drem [NUM_W];
    logic [NUM_W-1:0]      r_dq [NUM_W];
    logic [NUM_W-1:0]      r_dnum [NUM_W];
    logic [ROOT_W-1:0]     r_dnorm [NUM_W];
    logic                  r_dneg [NUM_W];
    logic [INDEX_BITS-1:0] r_drow [NUM_W];
    logic [INDEX_BITS-1:0] r_dcol [NUM_W];
    logic                  r_dlast [NUM_W];
    logic [DREM_W-1:0]     n_drem [NUM_W];
    logic [NUM_W-1:0]      n_dq [NUM_W];

    // output register
    logic                          r_ov;
    t_out                          r_od;
    logic signed [WEIGHT_BITS-1:0] n_weight;

    assign b_adv   = !r_ov || i_ready;
    assign f_adv   = b_adv && (!r_ser_v || r_cnt == 2'd2);
    assign o_ready = f_adv;
    assign o_valid = r_ov;
    assign o_data  = r_od;

    assign w_a = '{i_data.ax, i_data.ay, i_data.az};
    assign w_b = '{i_data.bx, i_data.by, i_data.bz};
    assign w_c = '{i_data.cx, i_data.cy, i_data.cz};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_mag[k] = r_cr[k][CROSS_W-1] ? CROSS_W'(-r_cr[k]) : CROSS_W'(r_cr[k]);
        end
    end

    // digit-by-digit floor root, two radicand bits per stage
    for (genvar s = 0; s < ROOT_W; s++) begin : g_sqrt
        logic [REM_W-1:0]  w_rem_i;
        logic [ROOT_W-1:0] w_root_i;
        logic [SUM_W-1:0]  w_rad_i;
        logic [REM_W-1:0]  w_cur;
        logic [REM_W-1:0]  w_trial;
        if (s == 0) begin : g_first
            assign w_rem_i  = '0;
            assign w_root_i = '0;
            assign w_rad_i  = r_sum;
        end else begin : g_next
            assign w_rem_i  = r_srem[s-1];
            assign w_root_i = r_sroot[s-1];
            assign w_rad_i  = r_srad[s-1];
        end
        assign w_cur      = {w_rem_i[REM_W-3:0], w_rad_i[SUM_W-1-2*s -: 2]};
        assign w_trial    = {w_root_i, 2'b01};
        assign n_srad[s]  = w_rad_i;
        assign n_srem[s]  = (w_cur >= w_trial) ? w_cur - w_trial : w_cur;
        assign n_sroot[s] = {w_root_i[ROOT_W-2:0], w_cur >= w_trial};
    end

    // front pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FRONT; i++) begin
                r_fv[i] <= 1'b0;
            end
        end else if (f_adv) begin
            r_fv[0] <= i_valid;
            for (int i = 1; i < FRONT; i++) begin
                r_fv[i] <= r_fv[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_adv) begin
            r_fidx[0] <= '{a: i_data.index_a, b: i_data.index_b, c: i_data.index_c};
            for (int i = 1; i < FRONT; i++) begin
                r_fidx[i] <= r_fidx[i-1];
            end
            for (int k = 0; k < 3; k++) begin
                r_dba[k] <= DIFF_W'(w_b[k]) - DIFF_W'(w_a[k]);
                r_dca[k] <= DIFF_W'(w_c[k]) - DIFF_W'(w_a[k]);
                r_dcb[k] <= DIFF_W'(w_c[k]) - DIFF_W'(w_b[k]);
                r_dab[k] <= DIFF_W'(w_a[k]) - DIFF_W'(w_b[k]);
                // (a-c).(b-c) = (c-a).(c-b); (c-b).(a-b); (b-a).(c-a)
                r_pc[k]  <= PROD_W'(r_dca[k]) * PROD_W'(r_dcb[k]);
                r_pb[k]  <= PROD_W'(r_dcb[k]) * PROD_W'(r_dab[k]);
                r_pa[k]  <= PROD_W'(r_dba[k]) * PROD_W'(r_dca[k]);
                r_sq[k]  <= SQ_W'(w_mag[k]) * SQ_W'(w_mag[k]);
            end
            // cross of (b-a) and (c-a)
            r_xp[0] <= PROD_W'(r_dba[1]) * PROD_W'(r_dca[2]);
            r_xn[0] <= PROD_W'(r_dba[2]) * PROD_W'(r_dca[1]);
            r_xp[1] <= PROD_W'(r_dba[2]) * PROD_W'(r_dca[0]);
            r_xn[1] <= PROD_W'(r_dba[0]) * PROD_W'(r_dca[2]);
            r_xp[2] <= PROD_W'(r_dba[0]) * PROD_W'(r_dca[1]);
            r_xn[2] <= PROD_W'(r_dba[1]) * PROD_W'(r_dca[0]);
            for (int k = 0; k < 3; k++) begin
                r_cr[k] <= CROSS_W'(r_xp[k]) - CROSS_W'(r_xn[k]);
            end
            r_fdot[0][0] <= DOT_W'(r_pc[0]) + DOT_W'(r_pc[1]) + DOT_W'(r_pc[2]);
            r_fdot[0][1] <= DOT_W'(r_pb[0]) + DOT_W'(r_pb[1]) + DOT_W'(r_pb[2]);
            r_fdot[0][2] <= DOT_W'(r_pa[0]) + DOT_W'(r_pa[1]) + DOT_W'(r_pa[2]);
            for (int i = 1; i < FRONT - 2; i++) begin
                r_fdot[i] <= r_fdot[i-1];
            end
            r_sum <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
            for (int s = 0; s < ROOT_W; s++) begin
                r_srem[s]  <= n_srem[s];
                r_sroot[s] <= n_sroot[s];
                r_srad[s]  <= n_srad[s];
            end
        end
    end

    // serializer: one division per cycle while the back end moves, three per triangle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_v <= 1'b0;
            r_cnt   <= 2'd0;
        end else if (f_adv) begin
            r_ser_v <= r_fv[FRONT-1];
            r_cnt   <= 2'd0;
        end else if (b_adv && r_ser_v) begin
            r_cnt <= r_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_adv) begin
            r_ser_idx  <= r_fidx[FRONT-1];
            r_ser_dot  <= r_fdot[FRONT-3];
            r_ser_norm <= r_sroot[ROOT_W-1];
        end
    end

    always_comb begin
        w_sel_dot  = r_ser_dot[r_cnt];
        w_sel_last = 1'b0;
        case (r_cnt)
            2'd0: begin
                w_sel_row = r_ser_idx.a;
                w_sel_col = r_ser_idx.b;
            end
            2'd1: begin
                w_sel_row = r_ser_idx.c;
                w_sel_col = r_ser_idx.a;
            end
            default: begin
                w_sel_row  = r_ser_idx.b;
                w_sel_col  = r_ser_idx.c;
                w_sel_last = 1'b1;
            end
        endcase
        w_sel_mag = w_sel_dot[DOT_W-1] ? DOT_W'(-w_sel_dot) : DOT_W'(w_sel_dot);
        w_sel_num = {w_sel_mag, {FRAC_BITS{1'b0}}};
    end

    // restoring divider, one quotient bit per stage
    for (genvar t = 0; t < NUM_W; t++) begin : g_div
        logic [DREM_W-1:0] w_rem_i;
        logic [NUM_W-1:0]  w_q_i;
        logic [NUM_W-1:0]  w_num_i;
        logic [ROOT_W-1:0] w_den_i;
        logic [DREM_W-1:0] w_cur;
        if (t == 0) begin : g_first
            assign w_rem_i = '0;
            assign w_q_i   = '0;
            assign w_num_i = w_sel_num;
            assign w_den_i = r_ser_norm;
        end else begin : g_next
            assign w_rem_i = r_drem[t-1];
            assign w_q_i   = r_dq[t-1];
            assign w_num_i = r_dnum[t-1];
            assign w_den_i = r_dnorm[t-1];
        end
        assign w_cur     = {w_rem_i[ROOT_W-1:0], w_num_i[NUM_W-1-t]};
        assign n_drem[t] = (w_cur >= {1'b0, w_den_i}) ? w_cur - {1'b0, w_den_i} : w_cur;
        assign n_dq[t]   = {w_q_i[NUM_W-2:0], w_cur >= {1'b0, w_den_i}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < NUM_W; t++) begin
                r_dv[t] <= 1'b0;
            end
        end else if (b_adv) begin
            r_dv[0] <= r_ser_v;
            for (int t = 1; t < NUM_W; t++) begin
                r_dv[t] <= r_dv[t-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_dnum[0]  <= w_sel_num;
            r_dnorm[0] <= r_ser_norm;
            r_dneg[0]  <= w_sel_dot[DOT_W-1];
            r_drow[0]  <= w_sel_row;
            r_dcol[0]  <= w_sel_col;
            r_dlast[0] <= w_sel_last;
            for (int t = 1; t < NUM_W; t++) begin
                r_dnum[t]  <= r_dnum[t-1];
                r_dnorm[t] <= r_dnorm[t-1];
                r_dneg[t]  <= r_dneg[t-1];
                r_drow[t]  <= r_drow[t-1];
                r_dcol[t]  <= r_dcol[t-1];
                r_dlast[t] <= r_dlast[t-1];
            end
            for (int t = 0; t < NUM_W; t++) begin
                r_drem[t] <= n_drem[t];
                r_dq[t]   <= n_dq[t];
            end
        end
    end

    // sign, saturation, degenerate triangle
    always_comb begin
        if (r_dnorm[NUM_W-1] == '0) begin
            n_weight = '0;
        end else if (r_dneg[NUM_W-1]) begin
            if (r_dq[NUM_W-1] >= (NUM_W'(1) << (WEIGHT_BITS - 1))) begin
                n_weight = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
            end else begin
                n_weight = WEIGHT_BITS'(0) - r_dq[NUM_W-1][WEIGHT_BITS-1:0];
            end
        end else if (r_dq[NUM_W-1] > {{(NUM_W-WEIGHT_BITS+1){1'b0}}, {(WEIGHT_BITS-1){1'b1}}})
        begin
            n_weight = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
        end else begin
            n_weight = r_dq[NUM_W-1][WEIGHT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (b_adv) begin
            r_ov <= r_dv[NUM_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_od.row_index <= r_drow[NUM_W-1];
            r_od.col_index <= r_dcol[NUM_W-1];
            r_od.weight    <= n_weight;
            r_od.last      <= r_dlast[NUM_W-1];
        end
    end

    // a new triangle enters only while the output can move
    a_accept_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (!o_valid || i_ready))
        else $error("input taken while output stalled");

    // the serializer never counts past the third triplet
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ser_v |-> (r_cnt != 2'd3))
        else $error("serializer count out of range");

    // a zero norm always yields a zero weight
    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_adv && r_dv[NUM_W-1] && r_dnorm[NUM_W-1] == '0) |=> (o_data.weight == '0))
        else $error("degenerate triangle gave nonzero weight");

endmodule

// ===== bench/cotangent_weight_triplets_tb.sv =====
// Testbench for cotangent_weight_triplets: drives random and directed triangles,
// predicts the three weight triplets per triangle and checks them in order.
// Depends on cwt_pkg and the cotangent_weight_triplets RTL.
module cotangent_weight_triplets_tb;
    import cwt_pkg::*;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  o_ready;
    t_in   i_data = '0;
    logic  o_valid;
    logic  i_ready = 1'b0;
    t_out  o_data;

    cotangent_weight_triplets dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    always #1 i_clk = ~i_clk;

    t_in  tri_q[$];      // triangles waiting to be offered
    t_out triplet_q[$];  // triplets predicted, oldest first
    int   errors = 0;
    bit   stim_done = 0;
    bit   drain_pause = 0; // sender holds until the triplet store empties
    int   rx_hold = 0;     // long receiver stall, cycles

    // floor square root, bit by bit
    function automatic longint unsigned floor_root(logic [127:0] n);
        longint unsigned r;
        logic [127:0] c;
        r = 0;
        for (int k = 63; k >= 0; k--) begin
            c = {64'd0, r | (64'd1 << k)};
            if (c * c <= n) r = r | (64'd1 << k);
        end
        return r;
    endfunction

    // cotangent of the angle at q, Q16.16 saturated
    function automatic logic [31:0] corner_cot(longint p[3], longint q[3], longint r[3]);
        longint u[3], w[3], e[3], f[3], cr[3];
        longint dot;
        logic [127:0] sq;
        longint unsigned nrm, mg;
        logic [127:0] quo;
        dot = 0;
        sq = 0;
        for (int i = 0; i < 3; i++) begin
            u[i] = p[i] - q[i]; w[i] = r[i] - q[i];
            e[i] = q[i] - p[i]; f[i] = r[i] - p[i];
            dot += u[i] * w[i];
        end
        cr[0] = e[1] * f[2] - e[2] * f[1];
        cr[1] = e[2] * f[0] - e[0] * f[2];
        cr[2] = e[0] * f[1] - e[1] * f[0];
        for (int i = 0; i < 3; i++) begin
            mg = cr[i] < 0 ? -cr[i] : cr[i];
            sq += {64'd0, mg} * {64'd0, mg};
        end
        if (sq == 0) return 32'd0;
        nrm = floor_root(sq);
        if (nrm == 0) return 32'd0;
        mg = dot < 0 ? -dot : dot;
        quo = ({64'd0, mg} << 16) / {64'd0, nrm};
        if (dot < 0) return quo >= 128'h8000_0000 ? 32'h8000_0000 : 32'(-quo);
        return quo > 128'h7fff_ffff ? 32'h7fff_ffff : quo[31:0];
    endfunction

    function automatic void predict_triplets(t_in t);
        longint a[3], b[3], c[3];
        a = '{longint'(t.ax), longint'(t.ay), longint'(t.az)};
        b = '{longint'(t.bx), longint'(t.by), longint'(t.bz)};
        c = '{longint'(t.cx), longint'(t.cy), longint'(t.cz)};
        triplet_q.push_back('{t.index_a, t.index_b, corner_cot(a, c, b), 1'b0});
        triplet_q.push_back('{t.index_c, t.index_a, corner_cot(c, b, a), 1'b0});
        triplet_q.push_back('{t.index_b, t.index_c, corner_cot(b, a, c), 1'b1});
    endfunction

    function automatic t_in rand_tri(int mode);
        t_in t;
        t = '0;
        t.index_a = 24'($urandom); t.index_b = 24'($urandom); t.index_c = 24'($urandom);
        if (mode == 0) begin
            // full range coordinates
            {t.ax, t.ay, t.az} = 48'({$urandom, $urandom});
            {t.bx, t.by, t.bz} = 48'({$urandom, $urandom});
            {t.cx, t.cy, t.cz} = 48'({$urandom, $urandom});
        end else if (mode == 1) begin
            // small triangle near a random point
            t.ax = 16'($urandom); t.ay = 16'($urandom); t.az = 16'($urandom);
            t.bx = t.ax + 16'($urandom_range(0, 64)) - 16'sd32;
            t.by = t.ay + 16'($urandom_range(0, 64)) - 16'sd32;
            t.bz = t.az + 16'($urandom_range(0, 64)) - 16'sd32;
            t.cx = t.ax + 16'($urandom_range(0, 64)) - 16'sd32;
            t.cy = t.ay + 16'($urandom_range(0, 64)) - 16'sd32;
            t.cz = t.az + 16'($urandom_range(0, 64)) - 16'sd32;
        end else begin
            // collinear or nearly so: degenerate and saturating weights
            t.ax = 16'($urandom_range(0, 200)) - 16'sd100; t.ay = 16'($urandom); t.az = 0;
            t.bx = t.ax + 16'sd50; t.by = t.ay + 16'sd50; t.bz = 16'($urandom_range(0, 1));
            t.cx = t.ax + 16'sd100; t.cy = t.ay + 16'sd100; t.cz = 0;
        end
        return t;
    endfunction

    initial begin
        t_in t;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: extremes, degenerate, right angle, saturation
        t = '0; tri_q.push_back(t);
        t = '1; tri_q.push_back(t);
        t = '0; t.index_a = '1; t.bx = 16'sd256; t.cy = 16'sd256; tri_q.push_back(t);
        t = '0; t.ax = 16'sh8000; t.ay = 16'sh8000; t.az = 16'sh8000;
        t.bx = 16'sh7fff; t.by = 16'sh7fff; t.bz = 16'sh7fff;
        t.cx = 16'sh8000; t.cy = 16'sh7fff; t.cz = 16'sh8000; tri_q.push_back(t);
        t = '0; t.bx = 16'sh7fff; t.cx = 16'sh8000; t.cy = 16'sd1; tri_q.push_back(t);
        t = '0; t.bx = 16'sd1; t.cx = 16'sh7fff; t.cy = 16'sd1; tri_q.push_back(t);
        t = '0; t.index_b = '1; t.ax = 16'sh7fff; t.bx = 16'sh7fff; t.cx = 16'sh7fff;
        tri_q.push_back(t);
        t = '0; t.index_c = 24'h5a5a5a; t.bx = 16'sd256; t.cx = 16'sd128;
        t.cy = 16'sd443; tri_q.push_back(t);
        for (int i = 0; i < 12; i++) tri_q.push_back(rand_tri(i % 3));
        for (int i = 0; i < 450; i++) begin
            if (i == 100) begin
                wait (tri_q.size() == 0);
                rx_hold = 400;          // receiver stalls while sender keeps going
            end
            if (i == 250) begin
                wait (tri_q.size() == 0);
                drain_pause = 1;
                // the last item offered must be taken before the store can drain
                @(posedge i_clk);
                wait (!i_valid && triplet_q.size() == 0);
                drain_pause = 0;
            end
            tri_q.push_back(rand_tri($urandom_range(0, 9) < 6 ? 0 :
                                     ($urandom_range(0, 1) ? 1 : 2)));
        end
        stim_done = 1;
    end

    // driver
    int tx_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                predict_triplets(i_data);
                tx_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 18) : 0;
            end
            if (i_valid && !o_ready) begin
                // hold the item
            end else if (tx_gap > 0) begin
                tx_gap--;
                i_valid <= 1'b0;
            end else if (tri_q.size() > 0 && !drain_pause) begin
                i_data  <= tri_q.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor: compare each accepted triplet with the oldest prediction
    int rx_gap = 0;
    always @(posedge i_clk) begin
        t_out exp_t;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (triplet_q.size() == 0) begin
                    $error("unexpected triplet %h", o_data);
                    errors++;
                end else begin
                    exp_t = triplet_q.pop_front();
                    if (o_data.row_index !== exp_t.row_index) begin
                        $error("row_index exp %h got %h", exp_t.row_index, o_data.row_index);
                        errors++;
                    end
                    if (o_data.col_index !== exp_t.col_index) begin
                        $error("col_index exp %h got %h", exp_t.col_index, o_data.col_index);
                        errors++;
                    end
                    if (o_data.weight !== exp_t.weight) begin
                        $error("weight exp %h got %h", exp_t.weight, o_data.weight);
                        errors++;
                    end
                    if (o_data.last !== exp_t.last) begin
                        $error("last exp %b got %b", exp_t.last, o_data.last);
                        errors++;
                    end
                end
                rx_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 18) : 0;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        wait (stim_done && tri_q.size() == 0);
        // the last offered item shows on i_valid once the driver has popped it
        @(posedge i_clk);
        wait (!i_valid);
        wait (triplet_q.size() == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && triplet_q.size() == 0)
            $display("cotangent_weight_triplets_tb: done, clean");
        else
            $display("cotangent_weight_triplets_tb: done, errors");
        $finish;
    end

    initial begin
        #400000;
        $display("cotangent_weight_triplets_tb: done, errors");
        $finish;
    end
endmodule
